// ===== hw/rtl/gsps_pkg.sv =====
// ----------------------------------------------------------------------------
// gsps_pkg - shared types and constants of the grid snap point store
// command codes, field widths and reset values
// ----------------------------------------------------------------------------
package gsps_pkg;

    localparam int GRID_SIDE_DEF  = 256;
    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 10;
    localparam int RESET_DIM      = 210;
    localparam int MAX_RADIUS     = 5;
    localparam int DIM_BITS       = 9;
    localparam int RAD_BITS       = 3;
    localparam int CFG_IDX_BITS   = 2;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_STORE  = 2'd1,
        CMD_STROKE = 2'd2,
        CMD_LOOKUP = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GRID_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SEARCH_RADIUS = 2'd2;

    localparam logic [1:0] KIND_ENDPOINT = 2'd0;
    localparam logic [1:0] KIND_LINE_CTR = 2'd1;

endpackage

// ===== hw/rtl/grid_snap_point_store.sv =====
// ----------------------------------------------------------------------------
// grid_snap_point_store - uniform grid snap point store
// stores typed points in grid cells and looks up the first stored neighbor
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one command transaction (clear, store, stroke point,
//   lookup); m_axis returns exactly one result transaction for each.
//   the block takes one command at a time and drops s_axis_tready while it
//   works and until the result has been taken on m_axis.
// sequencing (steps from the accepted command to the result valid)
//   clear, store, stroke start: the result follows the CALC state
//   stroke continuation: endpoint write in CALC, then midpoint write in WR2
//   lookup: scans the positions of the (2r+1)^2 square in order; a cell
//   inside the diamond and the grid is read as well; the scan stops at the
//   first valid cell, and a lookup outside the grid skips the scan
//   the block returns to idle once the result is taken
// storage
//   valid bits are epoch marks: a clear bumps an epoch counter. every 2^EW
//   clears a pass over all entries rewrites every mark (also after reset)
//   while s_axis is not ready; a clear command that wraps the epoch gives
//   its result after the pass. the user gives config writes only while idle,
//   the block does not enforce it; a register write clears the grid.
// stall
//   a stalled result holds on m_axis; nothing else but config writes moves.
// ----------------------------------------------------------------------------
module grid_snap_point_store #(
    parameter int GRID_SIDE  = gsps_pkg::GRID_SIDE_DEF,
    parameter int COORD_BITS = gsps_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = gsps_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // command[1:0], coord_x, coord_y, point_kind[1:0], padded to bytes
    input  logic [((2*COORD_BITS+4+7)/8)*8-1:0] s_axis_tdata,
    // stroke_start
    input  logic                     s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // found, snap_x, snap_y, snap_kind[1:0], in_grid, padded to bytes
    output logic [((2*COORD_BITS+5+7)/8)*8-1:0] m_axis_tdata,
    input  logic                     i_cfg_we,
    input  logic [gsps_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [gsps_pkg::DIM_BITS-1:0]     i_cfg_data
);
    import gsps_pkg::*;

    localparam int SB  = $clog2(GRID_SIDE);
    localparam int AW  = 2 * SB;
    localparam int CW  = SB + 3;
    localparam int EW  = 8;
    localparam int DW  = 2 * COORD_BITS + 2;
    localparam int OW  = (2*COORD_BITS+5+7)/8*8;
    localparam int DIM_MAX = (1 << DIM_BITS) - 1;
    localparam logic [DIM_BITS-1:0] SIDE_D =
        DIM_BITS'(GRID_SIDE > DIM_MAX ? DIM_MAX : GRID_SIDE);

    typedef enum logic [2:0] {
        ST_WIPE, ST_IDLE, ST_CALC, ST_WR2, ST_SCAN_A, ST_SCAN_R, ST_OUT
    } t_state;

    t_state r_state;
    logic [DIM_BITS-1:0] r_width, r_height;
    logic [RAD_BITS-1:0] r_radius;
    logic [EW-1:0]       r_epoch;
    logic [AW-1:0]       r_wipe;
    logic                r_wipe_out;
    logic [1:0]          r_cmd;
    logic signed [COORD_BITS-1:0] r_x, r_y, r_px, r_py;
    logic [1:0]          r_kind;
    logic                r_start;
    logic signed [RAD_BITS+1:0] r_i, r_j;
    logic signed [CW-1:0] r_cx, r_cy;
    logic                r_out_v;
    logic                r_found, r_hit;
    logic [DW-1:0]       r_res;

    // shared locate unit: endpoint in CALC, midpoint in WR2
    logic signed [COORD_BITS:0] w_lx, w_ly;
    logic signed [CW-1:0] w_cx, w_cy;
    logic w_inside;

    assign w_lx = (r_state == ST_WR2) ? ((COORD_BITS+1)'(r_px) + (COORD_BITS+1)'(r_x)) >>> 1
                                      : (COORD_BITS+1)'(r_x);
    assign w_ly = (r_state == ST_WR2) ? ((COORD_BITS+1)'(r_py) + (COORD_BITS+1)'(r_y)) >>> 1
                                      : (COORD_BITS+1)'(r_y);

    gsps_locate #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS), .CW(CW)) u_loc (
        .i_x(w_lx), .i_y(w_ly), .i_width(r_width), .i_height(r_height),
        .o_cx(w_cx), .o_cy(w_cy), .o_inside(w_inside)
    );

    // memories
    logic          w_we, w_vwe;
    logic [AW-1:0] w_waddr, w_vaddr;
    logic [DW-1:0] w_wdata, w_rdata;
    logic [EW:0]   w_wmark, w_rmark;
    logic [AW-1:0] w_raddr;

    gsps_cell_mem #(.AW(AW), .DW(DW)) u_cells (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );
    gsps_valid_mem #(.AW(AW), .EW(EW)) u_valid (
        .i_clk(i_clk), .i_we(w_vwe), .i_waddr(w_vaddr), .i_wmark(w_wmark),
        .i_raddr(w_raddr), .o_rmark(w_rmark)
    );

    // scan neighbor
    logic signed [CW-1:0] w_tx, w_ty;
    logic [RAD_BITS+1:0] w_ai, w_aj;
    logic w_ok;
    assign w_tx = r_cx + CW'(r_i);
    assign w_ty = r_cy + CW'(r_j);
    assign w_ai = r_i[RAD_BITS+1] ? (RAD_BITS+2)'(-r_i) : (RAD_BITS+2)'(r_i);
    assign w_aj = r_j[RAD_BITS+1] ? (RAD_BITS+2)'(-r_j) : (RAD_BITS+2)'(r_j);
    assign w_ok = ((w_ai + w_aj) <= (RAD_BITS+2)'(r_radius)) && (w_tx >= 0) && (w_ty >= 0)
               && (w_tx < CW'({1'b0, r_width})) && (w_ty < CW'({1'b0, r_height}));
    assign w_raddr = {w_tx[SB-1:0], w_ty[SB-1:0]};

    logic w_store;
    assign w_store = (r_state == ST_CALC) && (r_cmd == CMD_STORE || r_cmd == CMD_STROKE)
                   && w_inside;
    assign w_we    = w_store || ((r_state == ST_WR2) && w_inside);
    assign w_waddr = {w_cx[SB-1:0], w_cy[SB-1:0]};
    assign w_wdata = (r_state == ST_WR2)
        ? {w_lx[COORD_BITS-1:0], w_ly[COORD_BITS-1:0], KIND_LINE_CTR}
        : {r_x, r_y, (r_cmd == CMD_STORE) ? r_kind : KIND_ENDPOINT};
    assign w_vwe   = w_we || (r_state == ST_WIPE);
    assign w_vaddr = (r_state == ST_WIPE) ? r_wipe : w_waddr;
    assign w_wmark = (r_state == ST_WIPE) ? '0 : {1'b1, r_epoch};

    logic w_last_j, w_last_i;
    assign w_last_j = (r_j == (RAD_BITS+2)'(r_radius));
    assign w_last_i = (r_i == (RAD_BITS+2)'(r_radius));

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                      input logic [DIM_BITS-1:0] mx);
        logic [DIM_BITS-1:0] t;
        t = (v == '0) ? DIM_BITS'(1) : v;
        return (t > mx) ? mx : t;
    endfunction

    // an epoch increment that wraps needs a wipe
    logic w_clear;
    assign w_clear = (i_cfg_we && i_cfg_index <= REG_SEARCH_RADIUS)
                  || (r_state == ST_CALC && r_cmd == CMD_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_WIPE;
            r_wipe     <= '0;
            r_wipe_out <= 1'b0;
            r_epoch    <= '0;
            r_width  <= DIM_BITS'(RESET_DIM) > SIDE_D ? SIDE_D : DIM_BITS'(RESET_DIM);
            r_height <= DIM_BITS'(RESET_DIM) > SIDE_D ? SIDE_D : DIM_BITS'(RESET_DIM);
            r_radius <= RAD_BITS'(1);
            r_px     <= '0;
            r_py     <= '0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_GRID_WIDTH:  r_width  <= clamp_dim(i_cfg_data, SIDE_D);
                    REG_GRID_HEIGHT: r_height <= clamp_dim(i_cfg_data, SIDE_D);
                    REG_SEARCH_RADIUS: begin
                        r_radius <= (i_cfg_data[RAD_BITS-1:0] == '0) ? RAD_BITS'(1)
                                  : (i_cfg_data[RAD_BITS-1:0] > RAD_BITS'(MAX_RADIUS))
                                  ? RAD_BITS'(MAX_RADIUS) : i_cfg_data[RAD_BITS-1:0];
                    end
                    default: ;
                endcase
            end
            if (w_clear) begin
                r_epoch <= r_epoch + 1'b1;
            end
            case (r_state)
                ST_WIPE: begin
                    r_wipe <= r_wipe + 1'b1;
                    if (r_wipe == '1) begin
                        // a clear command waits for the pass before its result
                        if (r_wipe_out) begin
                            r_wipe_out <= 1'b0;
                            r_state    <= ST_OUT;
                            r_out_v    <= 1'b1;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_IDLE: begin
                    if (w_clear && r_epoch == '1) begin
                        r_state <= ST_WIPE;
                    end else if (s_axis_tvalid) begin
                        r_cmd   <= s_axis_tdata[1:0];
                        r_x     <= s_axis_tdata[2 +: COORD_BITS];
                        r_y     <= s_axis_tdata[2+COORD_BITS +: COORD_BITS];
                        r_kind  <= s_axis_tdata[2+2*COORD_BITS +: 2];
                        r_start <= s_axis_tuser;
                        r_state <= ST_CALC;
                    end
                end
                ST_CALC: begin
                    r_found <= 1'b0;
                    r_res   <= '0;
                    r_hit   <= (r_cmd != CMD_CLEAR) && w_inside;
                    r_cx    <= w_cx;
                    r_cy    <= w_cy;
                    r_i     <= -(RAD_BITS+2)'(r_radius);
                    r_j     <= -(RAD_BITS+2)'(r_radius);
                    if (r_cmd == CMD_CLEAR && r_epoch == '1) begin
                        r_state    <= ST_WIPE;
                        r_wipe_out <= 1'b1;
                    end else if (r_cmd == CMD_STROKE && !r_start) begin
                        r_state <= ST_WR2;
                    end else if (r_cmd == CMD_LOOKUP && w_inside) begin
                        r_state <= ST_SCAN_A;
                    end else begin
                        r_state <= ST_OUT;
                        r_out_v <= 1'b1;
                    end
                    if (r_cmd == CMD_STROKE && r_start) begin
                        r_px <= r_x;
                        r_py <= r_y;
                    end
                end
                ST_WR2: begin
                    r_px    <= r_x;
                    r_py    <= r_y;
                    r_state <= ST_OUT;
                    r_out_v <= 1'b1;
                end
                ST_SCAN_A: begin
                    if (w_ok) begin
                        r_state <= ST_SCAN_R;
                    end else if (w_last_j && w_last_i) begin
                        r_state <= ST_OUT;
                        r_out_v <= 1'b1;
                    end
                    if (!w_ok) begin
                        if (w_last_j) begin
                            r_j <= -(RAD_BITS+2)'(r_radius);
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                ST_SCAN_R: begin
                    if (w_rmark == {1'b1, r_epoch}) begin
                        r_found <= 1'b1;
                        r_res   <= w_rdata;
                        r_state <= ST_OUT;
                        r_out_v <= 1'b1;
                    end else if (w_last_j && w_last_i) begin
                        r_state <= ST_OUT;
                        r_out_v <= 1'b1;
                    end else begin
                        r_state <= ST_SCAN_A;
                        if (w_last_j) begin
                            r_j <= -(RAD_BITS+2)'(r_radius);
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_out_v <= 1'b0;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !(w_clear && r_epoch == '1);
    assign m_axis_tvalid = r_out_v;
    // cell word is {x, y, kind}; result goes out found first, in_grid last
    assign m_axis_tdata  = OW'({r_hit, r_res[1:0], r_res[2 +: COORD_BITS],
                                r_res[2+COORD_BITS +: COORD_BITS], r_found});

endmodule

// ===== hw/rtl/gsps_locate.sv =====
// ----------------------------------------------------------------------------
// gsps_locate - point to cell mapper
// rounds a fixed point pair half up, adds half the grid and checks bounds
// ----------------------------------------------------------------------------
module gsps_locate #(
    parameter int COORD_BITS = gsps_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = gsps_pkg::FRAC_BITS_DEF,
    parameter int CW         = 12
) (
    input  logic signed [COORD_BITS:0]   i_x,
    input  logic signed [COORD_BITS:0]   i_y,
    input  logic [gsps_pkg::DIM_BITS-1:0] i_width,
    input  logic [gsps_pkg::DIM_BITS-1:0] i_height,
    output logic signed [CW-1:0]          o_cx,
    output logic signed [CW-1:0]          o_cy,
    output logic                          o_inside
);
    import gsps_pkg::*;

    localparam int RW = COORD_BITS + 2;
    localparam logic signed [RW-1:0] HALF =
        (FRAC_BITS == 0) ? RW'(0) : RW'(64'sd1 <<< (FRAC_BITS > 0 ? FRAC_BITS - 1 : 0));

    logic signed [RW-1:0] w_rx;
    logic signed [RW-1:0] w_ry;
    logic signed [RW-1:0] w_fx;
    logic signed [RW-1:0] w_fy;
    logic signed [RW-1:0] w_cx;
    logic signed [RW-1:0] w_cy;

    // arithmetic shift is floor division by a power of two
    assign w_rx = (RW'(i_x) + HALF) >>> FRAC_BITS;
    assign w_ry = (RW'(i_y) + HALF) >>> FRAC_BITS;
    assign w_fx = w_rx + RW'({1'b0, i_width[DIM_BITS-1:1]});
    assign w_fy = w_ry + RW'({1'b0, i_height[DIM_BITS-1:1]});
    assign w_cx = w_fx;
    assign w_cy = w_fy;
    assign o_inside = (w_fx >= 0) && (w_fx < RW'({1'b0, i_width}))
                   && (w_fy >= 0) && (w_fy < RW'({1'b0, i_height}));
    // only meaningful when inside; then the value fits in CW bits
    assign o_cx = CW'(w_cx);
    assign o_cy = CW'(w_cy);

endmodule

// ===== hw/rtl/gsps_cell_mem.sv =====
// ----------------------------------------------------------------------------
// gsps_cell_mem - cell storage
// one write and one registered read a cycle, point and kind per cell
// ----------------------------------------------------------------------------
module gsps_cell_mem #(
    parameter int AW = 16,
    parameter int DW = 50
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/gsps_valid_mem.sv =====
// ----------------------------------------------------------------------------
// gsps_valid_mem - cell valid bits with epoch marks
// each entry stores the epoch it was written in; a clear bumps the epoch
// ----------------------------------------------------------------------------
module gsps_valid_mem #(
    parameter int AW = 16,
    parameter int EW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [EW:0]   i_wmark,
    input  logic [AW-1:0] i_raddr,
    output logic [EW:0]   o_rmark
);
    logic [EW:0] r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wmark;
        end
        o_rmark <= r_mem[i_raddr];
    end

endmodule

// ===== hw/rtl/gsps_checker.sv =====
// ----------------------------------------------------------------------------
// gsps_checker - port level checks of the grid snap point store
// one command in flight, results hold under stall, a miss has no payload
// ----------------------------------------------------------------------------
module gsps_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [55:0] m_axis_tdata
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("second accept");
    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[50:1] == '0)
        else $error("miss with payload");
endmodule

bind grid_snap_point_store gsps_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
